// ===== rtl/qcp_pkg.sv =====
// Shared widths, register codes and trust codes of the queue-to-class partition block.
package qcp_pkg;

    localparam int QIDX_W     = 8;  // queue index, queue count, offset
    localparam int CLS_W      = 3;  // class index
    localparam int CNT_W      = 8;  // per-class queue count
    localparam int UCC_W      = 4;  // user class count (divisor)
    localparam int TRUST_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUEUE_PAIR_COUNT = 3'd0,
        REG_USER_CLASS_COUNT = 3'd1,
        REG_TRUST_MODE       = 3'd2,
        REG_PCP_CLASS_MASK   = 3'd3,
        REG_DSCP_CLASS_MASK  = 3'd4,
        REG_DEFAULT_CLASS    = 3'd5,
        REG_DCB_ENABLE       = 3'd6
    } cfg_reg_t;

    // Trust modes; any other code selects no class mask
    localparam logic [TRUST_W-1:0] TRUST_PCP  = 2'd0;
    localparam logic [TRUST_W-1:0] TRUST_DSCP = 2'd1;

endpackage

// ===== rtl/qcp_query_if.sv =====
// Query channel: queue index and class index with valid/ready handshake.
interface qcp_query_if import qcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [QIDX_W-1:0] queue_index;
    logic [CLS_W-1:0]  class_index;

    modport source (output valid, output queue_index, output class_index, input ready);
    modport sink   (input valid, input queue_index, input class_index, output ready);
endinterface

// ===== rtl/qcp_result_if.sv =====
// Result channel: class of the queue and range of the class with valid/ready handshake.
interface qcp_result_if import qcp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CLS_W-1:0]  queue_class;
    logic              queue_in_use;
    logic [QIDX_W-1:0] class_queue_offset;
    logic [CNT_W-1:0]  class_queue_count;

    modport source (
        output valid, output queue_class, output queue_in_use,
        output class_queue_offset, output class_queue_count, input ready
    );
    modport sink (
        input valid, input queue_class, input queue_in_use,
        input class_queue_offset, input class_queue_count, output ready
    );
endinterface

// ===== rtl/queue_to_class_partition_unit.sv =====
// Top level of the queue-to-class partition block: config registers and five-stage lookup pipeline.
//
// Usage: software writes the seven configuration registers over the plain write
// port (cfg_wr_en, cfg_index, cfg_data) while no transaction is in flight. Each
// transaction on the query channel carries a queue index and a class index; the
// matching transaction on the result channel returns the class owning that queue,
// whether the queue is below the queue pair count, and the first queue and the
// queue count of the asked class.
// Throughput: one query per cycle while the result channel is not stalled. The
// per-class share is found by a restoring divider spread over the first three
// stages (three, three and two quotient bits), stage four builds the class
// ranges and stage five matches the queue.
// Reset clears all configuration registers and empties the pipeline.
// When the receiver stalls, the result register holds its transaction and each
// stage holds in turn as the stage after it fills; nothing is dropped or repeated,
// and the query channel keeps accepting while any stage is still empty.
module queue_to_class_partition_unit
    import qcp_pkg::*;
#(
    parameter int NUM_CLASSES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    qcp_query_if.sink             query,
    qcp_result_if.source          result
);

    typedef struct packed {
        logic [UCC_W-1:0]  rem;
        logic [QIDX_W-1:0] quo;
    } div_state_t;

    // One restoring division step: bring in one dividend bit, subtract if it fits
    function automatic div_state_t div_step(div_state_t s, logic b, logic [UCC_W-1:0] d);
        logic [UCC_W:0] t;
        div_state_t     o;
        t = {s.rem, b};
        if (t >= {1'b0, d})
        begin
            o.rem = UCC_W'(t - {1'b0, d});
            o.quo = {s.quo[QIDX_W-2:0], 1'b1};
        end
        else
        begin
            o.rem = t[UCC_W-1:0];
            o.quo = {s.quo[QIDX_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // Configuration registers
    logic [QIDX_W-1:0] queue_pair_count_reg;
    logic [UCC_W-1:0]  user_class_count_reg;
    logic [TRUST_W-1:0] trust_mode_reg;
    logic [7:0]        pcp_class_mask_reg;
    logic [7:0]        dscp_class_mask_reg;
    logic [CLS_W-1:0]  default_class_reg;
    logic              dcb_enable_reg;

    // Pipeline registers
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic              en1, en2, en3, en4, en5;
    logic [QIDX_W-1:0] s1_q_reg, s2_q_reg, s3_q_reg, s4_q_reg;
    logic [CLS_W-1:0]  s1_ci_reg, s2_ci_reg, s3_ci_reg, s4_ci_reg;
    div_state_t        s1_div_reg, s2_div_reg, s3_div_reg;
    div_state_t        s1_div_next, s2_div_next, s3_div_next;
    logic [QIDX_W-1:0] s4_off_reg [NUM_CLASSES];
    logic [CNT_W-1:0]  s4_cnt_reg [NUM_CLASSES];
    logic [QIDX_W-1:0] s4_off_next [NUM_CLASSES];
    logic [CNT_W-1:0]  s4_cnt_next [NUM_CLASSES];
    logic [CLS_W-1:0]  s5_class_reg, s5_class_next;
    logic              s5_in_use_reg, s5_in_use_next;
    logic [QIDX_W-1:0] s5_off_reg, s5_off_next;
    logic [CNT_W-1:0]  s5_cnt_reg, s5_cnt_next;
    logic [7:0]        class_mask;

    // Write configuration registers; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_pair_count_reg <= '0;
            user_class_count_reg <= '0;
            trust_mode_reg       <= '0;
            pcp_class_mask_reg   <= '0;
            dscp_class_mask_reg  <= '0;
            default_class_reg    <= '0;
            dcb_enable_reg       <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_QUEUE_PAIR_COUNT: queue_pair_count_reg <= cfg_data[QIDX_W-1:0];
                REG_USER_CLASS_COUNT: user_class_count_reg <= cfg_data[UCC_W-1:0];
                REG_TRUST_MODE:       trust_mode_reg       <= cfg_data[TRUST_W-1:0];
                REG_PCP_CLASS_MASK:   pcp_class_mask_reg   <= cfg_data[7:0];
                REG_DSCP_CLASS_MASK:  dscp_class_mask_reg  <= cfg_data[7:0];
                REG_DEFAULT_CLASS:    default_class_reg    <= cfg_data[CLS_W-1:0];
                REG_DCB_ENABLE:       dcb_enable_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or the stage after it advances
    assign en5 = !s5_valid_reg || result.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign query.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= query.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
            if (en5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // Divide queue pair count by user class count, three, three and two bits per stage
    always_comb
    begin
        div_state_t s;
        s = '0;
        for (int k = 0; k < 3; k++)
            s = div_step(s, queue_pair_count_reg[QIDX_W-1-k], user_class_count_reg);
        s1_div_next = s;
        s = s1_div_reg;
        for (int k = 3; k < 6; k++)
            s = div_step(s, queue_pair_count_reg[QIDX_W-1-k], user_class_count_reg);
        s2_div_next = s;
        s = s2_div_reg;
        for (int k = 6; k < QIDX_W; k++)
            s = div_step(s, queue_pair_count_reg[QIDX_W-1-k], user_class_count_reg);
        s3_div_next = s;
    end

    // Select the class mask of the trust mode
    always_comb
    begin
        priority if (trust_mode_reg == TRUST_DSCP)
            class_mask = dscp_class_mask_reg;
        else if (trust_mode_reg == TRUST_PCP)
            class_mask = pcp_class_mask_reg;
        else
            class_mask = '0;
    end

    // Build contiguous ranges: enabled classes in ascending order by rank
    always_comb
    begin
        logic [3:0]  rank;
        logic [11:0] prod;
        logic        extra;
        logic        ranges_on;
        rank      = '0;
        ranges_on = (user_class_count_reg != '0) && (s3_div_reg.quo != '0);
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            prod  = 12'(rank) * 12'(s3_div_reg.quo);
            extra = (rank < s3_div_reg.rem);
            prod  = prod + (extra ? 12'(rank) : 12'(s3_div_reg.rem));
            if (ranges_on && class_mask[c])
            begin
                s4_off_next[c] = prod[QIDX_W-1:0];
                s4_cnt_next[c] = s3_div_reg.quo + CNT_W'(extra);
                rank           = rank + 4'd1;
            end
            else
            begin
                s4_off_next[c] = '0;
                s4_cnt_next[c] = '0;
            end
        end
    end

    // Match the queue to each range (DCB on, highest class wins, default if none); pick the asked range
    always_comb
    begin
        logic [QIDX_W:0] range_end;
        s5_class_next = default_class_reg;
        s5_off_next   = '0;
        s5_cnt_next   = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            range_end = {1'b0, s4_off_reg[c]} + {1'b0, s4_cnt_reg[c]};
            if (dcb_enable_reg && s4_cnt_reg[c] != '0 && s4_q_reg >= s4_off_reg[c]
                && {1'b0, s4_q_reg} < range_end)
                s5_class_next = CLS_W'(c);
            if (s4_ci_reg == CLS_W'(c))
            begin
                s5_off_next = s4_off_reg[c];
                s5_cnt_next = s4_cnt_reg[c];
            end
        end
        s5_in_use_next = (s4_q_reg < queue_pair_count_reg);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_q_reg   <= query.queue_index;
            s1_ci_reg  <= query.class_index;
            s1_div_reg <= s1_div_next;
        end
        if (en2)
        begin
            s2_q_reg   <= s1_q_reg;
            s2_ci_reg  <= s1_ci_reg;
            s2_div_reg <= s2_div_next;
        end
        if (en3)
        begin
            s3_q_reg   <= s2_q_reg;
            s3_ci_reg  <= s2_ci_reg;
            s3_div_reg <= s3_div_next;
        end
        if (en4)
        begin
            s4_q_reg   <= s3_q_reg;
            s4_ci_reg  <= s3_ci_reg;
            s4_off_reg <= s4_off_next;
            s4_cnt_reg <= s4_cnt_next;
        end
        if (en5)
        begin
            s5_class_reg  <= s5_class_next;
            s5_in_use_reg <= s5_in_use_next;
            s5_off_reg    <= s5_off_next;
            s5_cnt_reg    <= s5_cnt_next;
        end
    end

    // Drive the result channel from the last stage
    assign result.valid              = s5_valid_reg;
    assign result.queue_class        = s5_class_reg;
    assign result.queue_in_use       = s5_in_use_reg;
    assign result.class_queue_offset = s5_off_reg;
    assign result.class_queue_count  = s5_cnt_reg;

endmodule

// ===== rtl/qcp_checker.sv =====
// Port-level assertions for the queue-to-class partition block and their bind.
module qcp_checker
    import qcp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input logic [CLS_W-1:0]  queue_class,
    input logic              queue_in_use,
    input logic [QIDX_W-1:0] class_queue_offset,
    input logic [CNT_W-1:0]  class_queue_count
);

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result transaction withdrawn while stalled");

    // A stalled result keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(queue_class) && $stable(queue_in_use)
            && $stable(class_queue_offset) && $stable(class_queue_count))
        else $error("result payload changed while stalled");

    // The pipeline comes out of reset empty
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !res_valid)
        else $error("result offered straight after reset");

    // A class without queues is always reported at offset zero
    a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && class_queue_count == '0 |-> class_queue_offset == '0)
        else $error("empty class range with nonzero offset");

endmodule

bind queue_to_class_partition_unit qcp_checker u_qcp_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (result.valid),
    .res_ready          (result.ready),
    .queue_class        (result.queue_class),
    .queue_in_use       (result.queue_in_use),
    .class_queue_offset (result.class_queue_offset),
    .class_queue_count  (result.class_queue_count)
);
